>>> rtl/core/assert_macros.svh
// Assertion macros shared by the rasterizer RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check the consequent in the same cycle as the antecedent.
`define MER_ASSERT_NOW(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("rasterizer assertion failed");

// Check the consequent in the cycle after the antecedent.
`define MER_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("rasterizer assertion failed");

`endif

>>> rtl/core/mer_pkg.sv
// Shared widths, command codes and interface structs of the ellipse rasterizer.
package mer_pkg;

    // Field and storage widths
    localparam int COORD_W    = 10;
    localparam int RAD_W      = 9;
    localparam int PIX_W      = 12;
    localparam int SQ_W       = 2 * RAD_W;
    localparam int DEC_W      = 44;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = COORD_W;

    // Multiplier operand and product widths
    localparam int MOPA_W = 2 * (COORD_W + 1);
    localparam int MOPB_W = SQ_W;
    localparam int MUL_W  = MOPA_W + MOPB_W;

    // Widths of held products
    localparam int UX_W = SQ_W + COORD_W + 1;
    localparam int UY_W = SQ_W + COORD_W;
    localparam int SX_W = 2 * (COORD_W + 1);
    localparam int SY_W = 2 * COORD_W;
    localparam int PC_W = 2 * SQ_W;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SEMI_A   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SEMI_B   = 2'd3;

    // Multiplier operations
    localparam logic [2:0] MOP_NONE = 3'd0;
    localparam logic [2:0] MOP_SQ   = 3'd1;  // a*a, b*b
    localparam logic [2:0] MOP_CMP  = 3'd2;  // b2*x, a2*y
    localparam logic [2:0] MOP_UPD  = 3'd3;  // b2*(x+1), a2*(y-1)
    localparam logic [2:0] MOP_SXY  = 3'd4;  // (2x+1)^2, (y-1)^2
    localparam logic [2:0] MOP_TERM = 3'd5;  // b2*(2x+1)^2, a2*(y-1)^2
    localparam logic [2:0] MOP_AB   = 3'd6;  // a2*b2
    localparam logic [2:0] MOP_A2B  = 3'd7;  // a2*b

    // Decision register operations
    localparam logic [1:0] DEC_HOLD    = 2'd0;
    localparam logic [1:0] DEC_RESTART = 2'd1;
    localparam logic [1:0] DEC_SWITCH  = 2'd2;
    localparam logic [1:0] DEC_STEP    = 2'd3;

    typedef struct packed {
        logic [2:0] mul_op;
        logic [1:0] dec_op;
    } t_dp_cmd;

    typedef struct packed {
        logic finished;
        logic region2;
        logic ge;
    } t_dp_stat;

    typedef struct packed {
        logic start_pts;
        logic start_done;
    } t_emit_cmd;

endpackage

>>> rtl/core/mer_ctrl.sv
// Controller state machine: sequences multiplies, decision updates and point emission.
`include "assert_macros.svh"

module mer_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_tvalid,
    output logic                o_tready,
    input  logic                i_restart,
    input  mer_pkg::t_dp_stat   i_stat,
    input  logic                i_emit_busy,
    output mer_pkg::t_dp_cmd    o_dp_cmd,
    output mer_pkg::t_emit_cmd  o_emit_cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SQ    = 4'd1;
    localparam logic [3:0] S_CMP   = 4'd2;
    localparam logic [3:0] S_UPD   = 4'd3;
    localparam logic [3:0] S_SXY   = 4'd4;
    localparam logic [3:0] S_TERM  = 4'd5;
    localparam logic [3:0] S_AB    = 4'd6;
    localparam logic [3:0] S_SWLD  = 4'd7;
    localparam logic [3:0] S_APPLY = 4'd8;
    localparam logic [3:0] S_A2B   = 4'd9;
    localparam logic [3:0] S_RLD   = 4'd10;

    logic [3:0] r_state;
    logic [3:0] n_state;
    logic       r_restart;
    logic       n_restart;
    logic       w_accept;
    logic       w_switch;

    // Take a request only when idle and the emitter has room
    assign o_tready = (r_state == S_IDLE) && !i_emit_busy;
    assign w_accept = i_tvalid && o_tready;
    assign w_switch = !i_stat.region2 && i_stat.ge;

    // Start point or done emission on a step request
    assign o_emit_cmd.start_pts  = w_accept && !i_restart && !i_stat.finished;
    assign o_emit_cmd.start_done = w_accept && !i_restart && i_stat.finished;

    // Next state and datapath commands
    always_comb begin
        n_state          = r_state;
        n_restart        = r_restart;
        o_dp_cmd.mul_op  = mer_pkg::MOP_NONE;
        o_dp_cmd.dec_op  = mer_pkg::DEC_HOLD;
        case (r_state)
            S_IDLE: begin
                if (w_accept && (i_restart || !i_stat.finished)) begin
                    n_state   = S_SQ;
                    n_restart = i_restart;
                end
            end
            S_SQ: begin
                o_dp_cmd.mul_op = mer_pkg::MOP_SQ;
                n_state = r_restart ? S_A2B : S_CMP;
            end
            S_CMP: begin
                o_dp_cmd.mul_op = mer_pkg::MOP_CMP;
                n_state = S_UPD;
            end
            S_UPD: begin
                o_dp_cmd.mul_op = mer_pkg::MOP_UPD;
                n_state = w_switch ? S_SXY : S_APPLY;
            end
            S_SXY: begin
                o_dp_cmd.mul_op = mer_pkg::MOP_SXY;
                n_state = S_TERM;
            end
            S_TERM: begin
                o_dp_cmd.mul_op = mer_pkg::MOP_TERM;
                n_state = S_AB;
            end
            S_AB: begin
                o_dp_cmd.mul_op = mer_pkg::MOP_AB;
                n_state = S_SWLD;
            end
            S_SWLD: begin
                o_dp_cmd.dec_op = mer_pkg::DEC_SWITCH;
                n_state = S_APPLY;
            end
            S_APPLY: begin
                // Hold x and y until the last point has been taken by the emitter
                if (!i_emit_busy) begin
                    o_dp_cmd.dec_op = mer_pkg::DEC_STEP;
                    n_state = S_IDLE;
                end
            end
            S_A2B: begin
                o_dp_cmd.mul_op = mer_pkg::MOP_A2B;
                n_state = S_RLD;
            end
            S_RLD: begin
                o_dp_cmd.dec_op = mer_pkg::DEC_RESTART;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_restart <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_restart <= n_restart;
        end
    end

    `MER_ASSERT_NEXT(a_restart_path, w_accept && i_restart, r_state == S_SQ && r_restart)
    `MER_ASSERT_NEXT(a_apply_waits, r_state == S_APPLY && i_emit_busy, r_state == S_APPLY)

endmodule

>>> rtl/core/mer_datapath.sv
// Datapath: shared multiplier lanes, product registers, position and decision state.
`include "assert_macros.svh"

module mer_datapath (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  mer_pkg::t_dp_cmd                i_cmd,
    input  logic [mer_pkg::RAD_W-1:0]       i_semi_a,
    input  logic [mer_pkg::RAD_W-1:0]       i_semi_b,
    output mer_pkg::t_dp_stat               o_stat,
    output logic [mer_pkg::COORD_W-1:0]     o_x,
    output logic [mer_pkg::COORD_W-1:0]     o_y
);

    localparam int COORD_W = mer_pkg::COORD_W;
    localparam int DEC_W   = mer_pkg::DEC_W;
    localparam int MOPA_W  = mer_pkg::MOPA_W;
    localparam int MOPB_W  = mer_pkg::MOPB_W;
    localparam int MUL_W   = mer_pkg::MUL_W;
    localparam int SQ_W    = mer_pkg::SQ_W;

    // Products
    logic [SQ_W-1:0]          r_a2;
    logic [SQ_W-1:0]          r_b2;
    logic [MUL_W-1:0]         r_pa;
    logic [MUL_W-1:0]         r_pb;
    logic [mer_pkg::PC_W-1:0] r_pc;
    logic [mer_pkg::UX_W-1:0] r_ux;
    logic [mer_pkg::UY_W-1:0] r_uy;
    logic [mer_pkg::SX_W-1:0] r_sx;
    logic [mer_pkg::SY_W-1:0] r_sy;

    // Walk state
    logic [COORD_W-1:0]      r_x;
    logic [COORD_W-1:0]      r_y;
    logic signed [DEC_W-1:0] r_dec;
    logic                    r_region2;
    logic                    r_finished;
    logic [COORD_W-1:0]      n_x;
    logic [COORD_W-1:0]      n_y;
    logic signed [DEC_W-1:0] n_dec;
    logic                    n_region2;
    logic                    n_finished;

    // Multiplier lanes
    logic [MOPA_W-1:0] w_opa1;
    logic [MOPB_W-1:0] w_opa2;
    logic [MOPA_W-1:0] w_opb1;
    logic [MOPB_W-1:0] w_opb2;
    logic [MUL_W-1:0]  w_prod_a;
    logic [MUL_W-1:0]  w_prod_b;

    logic [COORD_W:0]   w_x_inc;
    logic [COORD_W-1:0] w_y_dec;
    logic [COORD_W-1:0] w_ym1_abs;

    // Scaled decision terms
    logic signed [DEC_W-1:0] w_ux8;
    logic signed [DEC_W-1:0] w_uy8;
    logic signed [DEC_W-1:0] w_a2x4;
    logic signed [DEC_W-1:0] w_b2x4;
    logic signed [DEC_W-1:0] w_a2;
    logic signed [DEC_W-1:0] w_pa;
    logic signed [DEC_W-1:0] w_pb4;
    logic signed [DEC_W-1:0] w_pc4;
    logic                    w_dec_neg;
    logic                    w_dec_zero;

    assign w_x_inc   = {1'b0, r_x} + (COORD_W + 1)'(1);
    assign w_y_dec   = r_y - COORD_W'(1);
    assign w_ym1_abs = (r_y == '0) ? COORD_W'(1) : w_y_dec;

    // Select multiplier operands
    always_comb begin
        w_opa1 = '0;
        w_opa2 = '0;
        w_opb1 = '0;
        w_opb2 = '0;
        case (i_cmd.mul_op)
            mer_pkg::MOP_SQ: begin
                w_opa1 = MOPA_W'(i_semi_a);
                w_opa2 = MOPB_W'(i_semi_a);
                w_opb1 = MOPA_W'(i_semi_b);
                w_opb2 = MOPB_W'(i_semi_b);
            end
            mer_pkg::MOP_CMP: begin
                w_opa1 = MOPA_W'(r_x);
                w_opa2 = r_b2;
                w_opb1 = MOPA_W'(r_y);
                w_opb2 = r_a2;
            end
            mer_pkg::MOP_UPD: begin
                w_opa1 = MOPA_W'(w_x_inc);
                w_opa2 = r_b2;
                w_opb1 = MOPA_W'(w_y_dec);
                w_opb2 = r_a2;
            end
            mer_pkg::MOP_SXY: begin
                w_opa1 = MOPA_W'({r_x, 1'b1});
                w_opa2 = MOPB_W'({r_x, 1'b1});
                w_opb1 = MOPA_W'(w_ym1_abs);
                w_opb2 = MOPB_W'(w_ym1_abs);
            end
            mer_pkg::MOP_TERM: begin
                w_opa1 = MOPA_W'(r_sx);
                w_opa2 = r_b2;
                w_opb1 = MOPA_W'(r_sy);
                w_opb2 = r_a2;
            end
            mer_pkg::MOP_AB: begin
                w_opa1 = MOPA_W'(r_a2);
                w_opa2 = r_b2;
            end
            mer_pkg::MOP_A2B: begin
                w_opa1 = MOPA_W'(i_semi_b);
                w_opa2 = r_a2;
            end
            default: begin
            end
        endcase
    end

    assign w_prod_a = MUL_W'(w_opa1) * MUL_W'(w_opa2);
    assign w_prod_b = MUL_W'(w_opb1) * MUL_W'(w_opb2);

    // Register each product into its holding register
    always_ff @(posedge i_clk) begin
        case (i_cmd.mul_op)
            mer_pkg::MOP_SQ: begin
                r_a2 <= w_prod_a[SQ_W-1:0];
                r_b2 <= w_prod_b[SQ_W-1:0];
            end
            mer_pkg::MOP_CMP, mer_pkg::MOP_TERM: begin
                r_pa <= w_prod_a;
                r_pb <= w_prod_b;
            end
            mer_pkg::MOP_UPD: begin
                r_ux <= w_prod_a[mer_pkg::UX_W-1:0];
                r_uy <= w_prod_b[mer_pkg::UY_W-1:0];
            end
            mer_pkg::MOP_SXY: begin
                r_sx <= w_prod_a[mer_pkg::SX_W-1:0];
                r_sy <= w_prod_b[mer_pkg::SY_W-1:0];
            end
            mer_pkg::MOP_AB, mer_pkg::MOP_A2B: begin
                r_pc <= w_prod_a[mer_pkg::PC_W-1:0];
            end
            default: begin
            end
        endcase
    end

    assign w_ux8  = DEC_W'({r_ux, 3'b000});
    assign w_uy8  = DEC_W'({r_uy, 3'b000});
    assign w_a2x4 = DEC_W'({r_a2, 2'b00});
    assign w_b2x4 = DEC_W'({r_b2, 2'b00});
    assign w_a2   = DEC_W'(r_a2);
    assign w_pa   = DEC_W'(r_pa);
    assign w_pb4  = DEC_W'({r_pb, 2'b00});
    assign w_pc4  = DEC_W'({r_pc, 2'b00});

    assign w_dec_neg  = r_dec[DEC_W-1];
    assign w_dec_zero = (r_dec == '0);

    // Next walk state
    always_comb begin
        n_x        = r_x;
        n_y        = r_y;
        n_dec      = r_dec;
        n_region2  = r_region2;
        n_finished = r_finished;
        case (i_cmd.dec_op)
            mer_pkg::DEC_RESTART: begin
                n_x        = '0;
                n_y        = COORD_W'(i_semi_b);
                n_dec      = w_b2x4 - w_pc4 + w_a2;
                n_region2  = 1'b0;
                n_finished = 1'b0;
            end
            mer_pkg::DEC_SWITCH: begin
                n_dec     = w_pa + w_pb4 - w_pc4;
                n_region2 = 1'b1;
            end
            mer_pkg::DEC_STEP: begin
                if (!r_region2) begin
                    // Region one: x always advances, y drops on a non-negative decision
                    n_x = w_x_inc[COORD_W-1:0];
                    if (w_dec_neg) begin
                        n_dec = r_dec + w_ux8 + w_b2x4;
                    end else begin
                        n_dec = r_dec + w_ux8 - w_uy8 + w_b2x4;
                        n_y   = w_y_dec;
                    end
                end else if (r_y == '0) begin
                    n_finished = 1'b1;
                end else begin
                    // Region two: y always drops, x advances on a non-positive decision
                    n_y = w_y_dec;
                    if (!w_dec_neg && !w_dec_zero) begin
                        n_dec = r_dec + w_a2x4 - w_uy8;
                    end else begin
                        n_dec = r_dec + w_ux8 + w_a2x4 - w_uy8;
                        n_x   = w_x_inc[COORD_W-1:0];
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x        <= '0;
            r_y        <= '0;
            r_dec      <= '0;
            r_region2  <= 1'b0;
            r_finished <= 1'b1;
        end else begin
            r_x        <= n_x;
            r_y        <= n_y;
            r_dec      <= n_dec;
            r_region2  <= n_region2;
            r_finished <= n_finished;
        end
    end

    assign o_stat.finished = r_finished;
    assign o_stat.region2  = r_region2;
    assign o_stat.ge       = (r_pa >= r_pb);
    assign o_x = r_x;
    assign o_y = r_y;

    `MER_ASSERT_NEXT(a_r1_x_adv, i_cmd.dec_op == mer_pkg::DEC_STEP && !r_region2, r_x == $past(r_x) + 1'b1)

endmodule

>>> rtl/core/mer_emit.sv
// Point emitter: produces the four mirrored points or the done result into an output register.
`include "assert_macros.svh"

module mer_emit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  mer_pkg::t_emit_cmd              i_cmd,
    input  logic [mer_pkg::COORD_W-1:0]     i_center_x,
    input  logic [mer_pkg::COORD_W-1:0]     i_center_y,
    input  logic [mer_pkg::COORD_W-1:0]     i_x,
    input  logic [mer_pkg::COORD_W-1:0]     i_y,
    output logic                            o_busy,
    output logic                            o_tvalid,
    input  logic                            i_tready,
    output logic [mer_pkg::PIX_W-1:0]       o_px,
    output logic [mer_pkg::PIX_W-1:0]       o_py,
    output logic                            o_last,
    output logic                            o_done
);

    localparam int PIX_W = mer_pkg::PIX_W;

    localparam logic [1:0] PT_PP = 2'd0;  // (h+x, k+y)
    localparam logic [1:0] PT_MM = 2'd1;  // (h-x, k-y)
    localparam logic [1:0] PT_PM = 2'd2;  // (h+x, k-y)
    localparam logic [1:0] PT_MP = 2'd3;  // (h-x, k+y)

    logic             r_busy;
    logic [1:0]       r_cnt;
    logic             r_mode_done;
    logic             r_valid;
    logic [PIX_W-1:0] r_px;
    logic [PIX_W-1:0] r_py;
    logic             r_last;
    logic             r_done;

    logic             w_load;
    logic             w_last;
    logic [PIX_W-1:0] w_px;
    logic [PIX_W-1:0] w_py;
    logic [PIX_W-1:0] w_hx_p;
    logic [PIX_W-1:0] w_hx_m;
    logic [PIX_W-1:0] w_ky_p;
    logic [PIX_W-1:0] w_ky_m;

    // Load the output register when it is empty or being drained
    assign w_load = r_busy && (!r_valid || i_tready);
    assign w_last = r_mode_done || (r_cnt == PT_MP);
    // Busy as seen after this edge
    assign o_busy = r_busy && !(w_load && w_last);

    assign w_hx_p = PIX_W'(i_center_x) + PIX_W'(i_x);
    assign w_hx_m = PIX_W'(i_center_x) - PIX_W'(i_x);
    assign w_ky_p = PIX_W'(i_center_y) + PIX_W'(i_y);
    assign w_ky_m = PIX_W'(i_center_y) - PIX_W'(i_y);

    // Pick the mirrored point for this slot
    always_comb begin
        case (r_cnt)
            PT_PP: begin
                w_px = w_hx_p;
                w_py = w_ky_p;
            end
            PT_MM: begin
                w_px = w_hx_m;
                w_py = w_ky_m;
            end
            PT_PM: begin
                w_px = w_hx_p;
                w_py = w_ky_m;
            end
            PT_MP: begin
                w_px = w_hx_m;
                w_py = w_ky_p;
            end
            default: begin
                w_px = '0;
                w_py = '0;
            end
        endcase
        if (r_mode_done) begin
            w_px = '0;
            w_py = '0;
        end
    end

    // Sequence the slots; a new start overrides the final load
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_cnt       <= PT_PP;
            r_mode_done <= 1'b0;
        end else begin
            if (w_load) begin
                if (w_last) begin
                    r_busy <= 1'b0;
                end else begin
                    r_cnt <= r_cnt + 2'd1;
                end
            end
            if (i_cmd.start_pts) begin
                r_busy      <= 1'b1;
                r_cnt       <= PT_PP;
                r_mode_done <= 1'b0;
            end else if (i_cmd.start_done) begin
                r_busy      <= 1'b1;
                r_cnt       <= PT_PP;
                r_mode_done <= 1'b1;
            end
        end
    end

    // Output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= 1'b1;
        end else if (i_tready) begin
            r_valid <= 1'b0;
        end
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_px   <= w_px;
            r_py   <= w_py;
            r_last <= w_last;
            r_done <= r_mode_done;
        end
    end

    assign o_tvalid = r_valid;
    assign o_px     = r_px;
    assign o_py     = r_py;
    assign o_last   = r_last;
    assign o_done   = r_done;

    `MER_ASSERT_NOW(a_done_is_last, r_valid && r_done, r_last)
    `MER_ASSERT_NEXT(a_last_ends, w_load && w_last && !i_cmd.start_pts && !i_cmd.start_done, !r_busy)

endmodule

>>> rtl/core/midpoint_ellipse_rasterizer.sv
// Step request: acceptance starts the emitter, whose output register then takes the first point;
// the four points follow on consecutive cycles while the result side is ready. A step passes
// the idle, SQ, CMP, UPD and APPLY states, plus SXY, TERM, AB and SWLD when it enters region two;
// a restart passes SQ, A2B and RLD. After the ellipse ends each step gives one done result.
// Reset is synchronous, active low: state registers clear to zero; the walk is marked finished.
// Top level: configuration registers, controller, datapath and point emitter.
module midpoint_ellipse_rasterizer (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Configuration write port
    input  logic                              i_cfg_we,
    input  logic [mer_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [mer_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    // Request stream
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [7:0]                        s_axis_tdata,   // [0] restart, [7:1] zero
    // Result stream
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [2*mer_pkg::PIX_W-1:0]       m_axis_tdata,   // [11:0] pixel_x, [23:12] pixel_y
    output logic                              m_axis_tlast,   // last_of_step
    output logic                              m_axis_tuser    // done_res
);

    logic [mer_pkg::COORD_W-1:0] r_center_x;
    logic [mer_pkg::COORD_W-1:0] r_center_y;
    logic [mer_pkg::RAD_W-1:0]   r_semi_a;
    logic [mer_pkg::RAD_W-1:0]   r_semi_b;

    mer_pkg::t_dp_cmd   w_dp_cmd;
    mer_pkg::t_dp_stat  w_dp_stat;
    mer_pkg::t_emit_cmd w_emit_cmd;
    logic                        w_emit_busy;
    logic [mer_pkg::COORD_W-1:0] w_x;
    logic [mer_pkg::COORD_W-1:0] w_y;
    logic [mer_pkg::PIX_W-1:0]   w_px;
    logic [mer_pkg::PIX_W-1:0]   w_py;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_x <= '0;
            r_center_y <= '0;
            r_semi_a   <= '0;
            r_semi_b   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                mer_pkg::CFG_CENTER_X: r_center_x <= i_cfg_data[mer_pkg::COORD_W-1:0];
                mer_pkg::CFG_CENTER_Y: r_center_y <= i_cfg_data[mer_pkg::COORD_W-1:0];
                mer_pkg::CFG_SEMI_A:   r_semi_a   <= i_cfg_data[mer_pkg::RAD_W-1:0];
                mer_pkg::CFG_SEMI_B:   r_semi_b   <= i_cfg_data[mer_pkg::RAD_W-1:0];
                default: begin
                end
            endcase
        end
    end

    mer_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tvalid    (s_axis_tvalid),
        .o_tready    (s_axis_tready),
        .i_restart   (s_axis_tdata[0]),
        .i_stat      (w_dp_stat),
        .i_emit_busy (w_emit_busy),
        .o_dp_cmd    (w_dp_cmd),
        .o_emit_cmd  (w_emit_cmd)
    );

    mer_datapath u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_dp_cmd),
        .i_semi_a (r_semi_a),
        .i_semi_b (r_semi_b),
        .o_stat   (w_dp_stat),
        .o_x      (w_x),
        .o_y      (w_y)
    );

    mer_emit u_emit (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_emit_cmd),
        .i_center_x (r_center_x),
        .i_center_y (r_center_y),
        .i_x        (w_x),
        .i_y        (w_y),
        .o_busy     (w_emit_busy),
        .o_tvalid   (m_axis_tvalid),
        .i_tready   (m_axis_tready),
        .o_px       (w_px),
        .o_py       (w_py),
        .o_last     (m_axis_tlast),
        .o_done     (m_axis_tuser)
    );

    // Pack the point, x in the low bits
    assign m_axis_tdata = {w_py, w_px};

endmodule

>>> bench/mer_checker.sv
// Point checker for the ellipse rasterizer: mirrors the walk and compares every emitted point.
`timescale 1ns / 100ps

module mer_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [mer_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [mer_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           s_axis_tvalid,
    input  logic                           s_axis_tready,
    input  logic [7:0]                     s_axis_tdata,   // [0] restart, [7:1] zero
    input  logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    input  logic [2*mer_pkg::PIX_W-1:0]    m_axis_tdata,   // [11:0] pixel_x, [23:12] pixel_y
    input  logic                           m_axis_tlast,   // last_of_step
    input  logic                           m_axis_tuser,   // done_res
    output int                             o_fail_count,
    output int                             o_pending
);

    localparam int MAX_PRINT = 30;

    typedef struct packed {
        logic [mer_pkg::PIX_W-1:0] px;
        logic [mer_pkg::PIX_W-1:0] py;
        logic                      last;
        logic                      done;
    } t_pixel;

    // Points still owed by the block, oldest first
    t_pixel pending_points[$];
    t_pixel want_pt;

    // Shadow copy of the configuration registers
    logic [mer_pkg::COORD_W-1:0] cen_x;
    logic [mer_pkg::COORD_W-1:0] cen_y;
    logic [mer_pkg::RAD_W-1:0]   axis_a;
    logic [mer_pkg::RAD_W-1:0]   axis_b;

    // Shadow copy of the walk state
    logic [mer_pkg::COORD_W-1:0] walk_x;
    logic [mer_pkg::COORD_W-1:0] walk_y;
    longint                      decision_x4;
    logic                        region_two;
    logic                        walk_done;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (o_fail_count < MAX_PRINT)
            $display("mismatch at %0t: %s got 0x%0h want 0x%0h", $time, what, got, want);
        o_fail_count = o_fail_count + 1;
    endtask

    function automatic void push_point(input longint px, input longint py,
                                       input logic last, input logic done);
        t_pixel p;
        p.px   = px[mer_pkg::PIX_W-1:0];
        p.py   = py[mer_pkg::PIX_W-1:0];
        p.last = last;
        p.done = done;
        pending_points.push_back(p);
    endfunction

    // Advance the shadow walk by one request and queue the points it owes
    task automatic walk_step(input logic restart);
        longint aa;
        longint bb;
        longint a2;
        longint b2;
        longint xx;
        longint yy;
        longint hh;
        longint kk;
        aa = longint'(axis_a);
        bb = longint'(axis_b);
        a2 = aa * aa;
        b2 = bb * bb;
        if (restart) begin
            walk_x      = '0;
            walk_y      = {1'b0, axis_b};
            decision_x4 = 4 * b2 - 4 * a2 * bb + a2;
            region_two  = 1'b0;
            walk_done   = 1'b0;
        end else if (walk_done) begin
            push_point(0, 0, 1'b1, 1'b1);
        end else begin
            xx = longint'(walk_x);
            yy = longint'(walk_y);
            hh = longint'(cen_x);
            kk = longint'(cen_y);
            // Switch regions once the slope passes -1
            if (!region_two && !(b2 * xx < a2 * yy)) begin
                decision_x4 = b2 * (2 * xx + 1) * (2 * xx + 1)
                            + 4 * a2 * (yy - 1) * (yy - 1)
                            - 4 * a2 * b2;
                region_two = 1'b1;
            end
            push_point(hh + xx, kk + yy, 1'b0, 1'b0);
            push_point(hh - xx, kk - yy, 1'b0, 1'b0);
            push_point(hh + xx, kk - yy, 1'b0, 1'b0);
            push_point(hh - xx, kk + yy, 1'b1, 1'b0);
            if (!region_two) begin
                if (decision_x4 < 0) begin
                    decision_x4 = decision_x4 + 4 * (2 * b2 * (xx + 1) + b2);
                end else begin
                    decision_x4 = decision_x4
                                + 4 * (2 * b2 * (xx + 1) - 2 * a2 * (yy - 1) + b2);
                    yy = yy - 1;
                end
                xx = xx + 1;
            end else if (yy <= 0) begin
                walk_done = 1'b1;
            end else begin
                if (decision_x4 > 0) begin
                    decision_x4 = decision_x4 + 4 * (a2 - 2 * a2 * (yy - 1));
                end else begin
                    decision_x4 = decision_x4
                                + 4 * (2 * b2 * (xx + 1) + a2 - 2 * a2 * (yy - 1));
                    xx = xx + 1;
                end
                yy = yy - 1;
            end
            walk_x = xx[mer_pkg::COORD_W-1:0];
            walk_y = yy[mer_pkg::COORD_W-1:0];
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            // Clear registers and mark the walk finished
            cen_x       = '0;
            cen_y       = '0;
            axis_a      = '0;
            axis_b      = '0;
            walk_x      = '0;
            walk_y      = '0;
            decision_x4 = 0;
            region_two  = 1'b0;
            walk_done   = 1'b1;
            pending_points.delete();
        end else begin
            // Compare each accepted point with the oldest one owed
            if (m_axis_tvalid && m_axis_tready) begin
                if (pending_points.size() == 0) begin
                    report_mismatch("unexpected point", 32'(m_axis_tdata), '0);
                end else begin
                    want_pt = pending_points.pop_front();
                    if (m_axis_tdata[mer_pkg::PIX_W-1:0] !== want_pt.px)
                        report_mismatch("pixel_x", 32'(m_axis_tdata[mer_pkg::PIX_W-1:0]),
                                        32'(want_pt.px));
                    if (m_axis_tdata[2*mer_pkg::PIX_W-1:mer_pkg::PIX_W] !== want_pt.py)
                        report_mismatch("pixel_y",
                                        32'(m_axis_tdata[2*mer_pkg::PIX_W-1:mer_pkg::PIX_W]),
                                        32'(want_pt.py));
                    if (m_axis_tlast !== want_pt.last)
                        report_mismatch("last_of_step", 32'(m_axis_tlast), 32'(want_pt.last));
                    if (m_axis_tuser !== want_pt.done)
                        report_mismatch("done_res", 32'(m_axis_tuser), 32'(want_pt.done));
                end
            end
            // Predict the points of each accepted request
            if (s_axis_tvalid && s_axis_tready)
                walk_step(s_axis_tdata[0]);
            // Track register writes
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    mer_pkg::CFG_CENTER_X: cen_x  = i_cfg_data;
                    mer_pkg::CFG_CENTER_Y: cen_y  = i_cfg_data;
                    mer_pkg::CFG_SEMI_A:   axis_a = i_cfg_data[mer_pkg::RAD_W-1:0];
                    mer_pkg::CFG_SEMI_B:   axis_b = i_cfg_data[mer_pkg::RAD_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
        o_pending = pending_points.size();
    end

endmodule

>>> bench/tb_top.sv
// Top of the ellipse rasterizer bench: clock, reset, requests, configuration and verdict.
`timescale 1ns / 100ps

module tb_top;

    localparam int RANDOM_ITEMS = 247;
    localparam int TAIL_CYCLES  = 24;
    localparam int CYCLE_LIMIT  = 400000;

    logic                           i_clk;
    logic                           i_rst_n       = 1'b0;
    logic                           i_cfg_we      = 1'b0;
    logic [mer_pkg::CFG_IDX_W-1:0]  i_cfg_idx     = '0;
    logic [mer_pkg::CFG_DATA_W-1:0] i_cfg_data    = '0;
    logic                           s_axis_tvalid = 1'b0;
    logic                           s_axis_tready;
    logic [7:0]                     s_axis_tdata  = '0;   // [0] restart, [7:1] zero
    logic                           m_axis_tvalid;
    logic                           m_axis_tready = 1'b0;
    logic [2*mer_pkg::PIX_W-1:0]    m_axis_tdata;         // [11:0] pixel_x, [23:12] pixel_y
    logic                           m_axis_tlast;         // last_of_step
    logic                           m_axis_tuser;         // done_res

    int   fail_count;
    int   pending;
    int   cycle_count = 0;
    int   ready_hold  = 0;
    logic quiet_mode  = 1'b0;

    midpoint_ellipse_rasterizer uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    mer_checker point_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Abort a run that hangs
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL midpoint_ellipse_rasterizer");
            $finish;
        end
    end

    // Gap length: mostly none, some short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet_mode || r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // Stall the result side at random
    always @(posedge i_clk) begin
        if (ready_hold != 0) begin
            ready_hold    <= ready_hold - 1;
            m_axis_tready <= 1'b0;
        end else if (!quiet_mode && $urandom_range(0, 3) == 0) begin
            ready_hold    <= ($urandom_range(0, 99) < 90) ? $urandom_range(0, 2)
                                                          : $urandom_range(8, 40);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Write all four registers on consecutive cycles
    task automatic write_config(input int cx, input int cy, input int ax, input int bx);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= mer_pkg::CFG_CENTER_X;
        i_cfg_data <= cx[mer_pkg::CFG_DATA_W-1:0];
        @(posedge i_clk);
        i_cfg_idx  <= mer_pkg::CFG_CENTER_Y;
        i_cfg_data <= cy[mer_pkg::CFG_DATA_W-1:0];
        @(posedge i_clk);
        i_cfg_idx  <= mer_pkg::CFG_SEMI_A;
        i_cfg_data <= ax[mer_pkg::CFG_DATA_W-1:0];
        @(posedge i_clk);
        i_cfg_idx  <= mer_pkg::CFG_SEMI_B;
        i_cfg_data <= bx[mer_pkg::CFG_DATA_W-1:0];
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // Offer one request, after a random gap, and hold it until accepted
    task automatic send_request(input logic restart);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, restart};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    // Hold off requests until every owed point has come, then let the block settle
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    function automatic int pick_axis(input int sel);
        if (sel == 0)
            return $urandom_range(400, 511);
        else if (sel < 4)
            return $urandom_range(13, 40);
        else
            return $urandom_range(0, 12);
    endfunction

    function automatic int pick_center();
        int r;
        r = $urandom_range(0, 7);
        if (r == 0)
            return 0;
        else if (r == 1)
            return 1023;
        else
            return $urandom_range(0, 1023);
    endfunction

    initial begin
        int   sent;
        int   steps;
        int   ax;
        int   bx;
        logic keep_walk;
        sent = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Step before any restart: nothing to draw, done only
        send_request(1'b0);
        send_request(1'b0);
        drain_results();

        // Both axes zero: a single row of points at the center, then done
        write_config(0, 0, 0, 0);
        send_request(1'b1);
        send_request(1'b0);
        send_request(1'b0);
        drain_results();

        // Zero horizontal axis at the far corner
        write_config(1023, 1023, 0, 3);
        send_request(1'b1);
        repeat (5) send_request(1'b0);
        drain_results();

        // Largest axes, restarted mid-walk and twice in a row
        write_config(0, 1023, 511, 511);
        send_request(1'b1);
        repeat (4) send_request(1'b0);
        send_request(1'b1);
        send_request(1'b1);
        repeat (2) send_request(1'b0);
        drain_results();

        // Zero vertical axis
        write_config(1023, 0, 3, 0);
        send_request(1'b1);
        repeat (2) send_request(1'b0);
        drain_results();

        // Random ellipses, mostly small, walked to the end unless an axis is above 64
        while (sent < RANDOM_ITEMS) begin
            quiet_mode <= ($urandom_range(0, 3) == 0);
            ax = pick_axis($urandom_range(0, 19));
            bx = pick_axis($urandom_range(0, 19));
            write_config(pick_center(), pick_center(), ax, bx);
            // Now and then keep the old walk going under the new registers
            keep_walk = ($urandom_range(0, 5) == 0);
            if (!keep_walk) begin
                send_request(1'b1);
                sent++;
            end
            if (ax > 64 || bx > 64)
                steps = 24;
            else
                steps = ax + bx + 3 + $urandom_range(0, 2);
            for (int n = 0; n < steps && sent < RANDOM_ITEMS; n++) begin
                if ($urandom_range(0, 39) == 0)
                    drain_results();
                // Break the sequence with a stray restart now and then
                send_request($urandom_range(0, 24) == 0);
                sent++;
            end
            drain_results();
        end

        if (fail_count == 0 && pending == 0) begin
            $display("PASS midpoint_ellipse_rasterizer");
        end else begin
            $display("FAIL midpoint_ellipse_rasterizer");
        end
        $finish;
    end

endmodule
